// ===== hw/rtl/gssr_pkg.sv =====
package gssr_pkg;

	// Number of serial bits shifted in after the parallel sample.
	localparam logic [3:0] SCAN_BITS = 4'd7;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;

	localparam logic [7:0] AXIS_LOW    = 8'h00;
	localparam logic [7:0] AXIS_CENTRE = 8'h80;
	localparam logic [7:0] AXIS_HIGH   = 8'hff;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_SETTLE   = 5'b00010,
		PH_CLK_HIGH = 5'b00100,
		PH_CLK_LOW  = 5'b01000,
		PH_DONE     = 5'b10000
	} phase_t;

	// One result item, most significant field first.
	typedef struct packed {
		logic [7:0] report_buttons;
		logic [7:0] report_y;
		logic [7:0] report_x;
		logic       report_valid;
		logic       busy_res;
		logic       clock_level;
		logic       scan_mode;
	} res_t;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] buttons;
	} report_t;

	// Capture bits are active low; left beats right and up beats down.
	function automatic report_t build_report(input logic [14:0] cap);
		report_t r;
		r.x = AXIS_CENTRE;
		r.y = AXIS_CENTRE;
		if (!cap[3]) r.x = AXIS_HIGH;
		if (!cap[2]) r.x = AXIS_LOW;
		if (!cap[1]) r.y = AXIS_HIGH;
		if (!cap[0]) r.y = AXIS_LOW;
		r.buttons[0] = ~cap[10];
		r.buttons[1] = ~cap[5] | ~cap[8];
		r.buttons[2] = ~cap[4] | ~cap[9];
		r.buttons[3] = ~cap[11];
		r.buttons[4] = ~cap[13];
		r.buttons[5] = ~cap[12];
		r.buttons[6] = 1'b0;
		r.buttons[7] = ~cap[14];
		return r;
	endfunction

endpackage

// ===== hw/rtl/gamepad_serial_scan_reporter.sv =====
// Gamepad serial scan reporter.
//
// Every input item on the s_ side is one timer tick carrying the start request and the
// current pin levels. Every accepted tick yields exactly one result item on the m_ side
// with the pin drive levels, the busy flag and, when a scan has just finished with a
// capture that differs from the last one reported, the x, y and button report.
// A scan settles for one half period with the pins released, samples the direction,
// fire and data pins, then clocks seven serial bits in, each taking two half periods.
// The half period in ticks is set through cfg_wen/cfg_wdata, which the user must write
// only while the block is idle; the block itself does not enforce this.
// The result of a tick is registered in the output buffer before m_tvalid shows it.
// Throughput: one tick per cycle while s_tready is high; the whole state update is a
// single pass of logic between the state registers and the output buffer.
// When the receiver stalls, a two-entry output buffer (output register plus skid
// register) holds results; s_tready falls only once both entries are occupied, so one
// further tick is still taken while a finished result waits.
// Reset clears the scan state, the last reported capture and both buffer entries, and
// loads a half period of 100 ticks.
module gamepad_serial_scan_reporter
	import gssr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// bit 0 start_req, bits 4:1 dir_pins, bit 5 fire_pin, bit 6 data_pin, bit 7 zero
	input  logic [7:0]  s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// bit 0 scan_mode, bit 1 clock_level, bit 2 busy_res, bit 3 report_valid,
	// bits 11:4 report_x, bits 19:12 report_y, bits 27:20 report_buttons, 31:28 zero
	output logic [31:0] m_tdata
);

	logic [15:0] half_q;
	phase_t      phase_q, phase_d;
	logic [15:0] wait_q, wait_d;
	logic [2:0]  bit_q, bit_d;
	logic [14:0] cap_q, cap_d;
	logic [14:0] last_q, last_d;

	logic        out_v_q, skid_v_q;
	res_t        out_q, skid_q;

	logic        push, pop;
	logic        start_req, fire_pin, data_pin;
	logic [3:0]  dir_pins;
	logic [16:0] wait_next;
	logic        wait_done;
	logic [15:0] serial_bit;
	logic        rep_valid;
	report_t     rep;
	res_t        res;

	assign start_req = s_tdata[0];
	assign dir_pins  = s_tdata[4:1];
	assign fire_pin  = s_tdata[5];
	assign data_pin  = s_tdata[6];

	assign s_tready = ~skid_v_q;
	assign push     = s_tvalid & s_tready;
	assign pop      = out_v_q & m_tready;

	// A half period of zero ends every wait after one tick, as a half period of one does.
	assign wait_next  = {1'b0, wait_q} + 17'd1;
	assign wait_done  = wait_next[16] | (wait_next[15:0] >= half_q);
	assign serial_bit = 16'(data_pin) << ({1'b0, bit_q} + 4'd8);

	always_comb begin
		phase_d   = phase_q;
		wait_d    = wait_q;
		bit_d     = bit_q;
		cap_d     = cap_q;
		last_d    = last_q;
		rep_valid = 1'b0;
		case (phase_q)
			PH_SETTLE: begin
				wait_d = wait_done ? 16'd0 : wait_next[15:0];
				if (wait_done) begin
					cap_d   = {9'd0, data_pin, fire_pin, dir_pins};
					bit_d   = 3'd0;
					phase_d = PH_CLK_HIGH;
				end
			end
			PH_CLK_HIGH: begin
				wait_d = wait_done ? 16'd0 : wait_next[15:0];
				if (wait_done) begin
					phase_d = PH_CLK_LOW;
				end
			end
			PH_CLK_LOW: begin
				wait_d = wait_done ? 16'd0 : wait_next[15:0];
				if (wait_done) begin
					cap_d = cap_q | serial_bit[14:0];
					if (({1'b0, bit_q} + 4'd1) >= SCAN_BITS) begin
						bit_d   = 3'd0;
						phase_d = PH_DONE;
						if (cap_d != last_q) begin
							rep_valid = 1'b1;
							last_d    = cap_d;
						end
					end else begin
						bit_d   = bit_q + 3'd1;
						phase_d = PH_CLK_HIGH;
					end
				end
			end
			default: begin
				// Idle, or finished with the pins still driven and the clock high.
				if (phase_q != PH_DONE) phase_d = PH_IDLE;
				if (start_req) begin
					phase_d = PH_SETTLE;
					wait_d  = 16'd0;
					bit_d   = 3'd0;
				end
			end
		endcase
	end

	always_comb begin
		rep                = build_report(cap_d);
		res.scan_mode      = (phase_d == PH_CLK_HIGH) | (phase_d == PH_CLK_LOW) |
		                     (phase_d == PH_DONE);
		res.clock_level    = (phase_d == PH_CLK_HIGH) | (phase_d == PH_DONE);
		res.busy_res       = (phase_d == PH_SETTLE) | (phase_d == PH_CLK_HIGH) |
		                     (phase_d == PH_CLK_LOW);
		res.report_valid   = rep_valid;
		res.report_x       = rep_valid ? rep.x : 8'd0;
		res.report_y       = rep_valid ? rep.y : 8'd0;
		res.report_buttons = rep_valid ? rep.buttons : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_PERIOD_RESET;
		end else if (cfg_wen) begin
			half_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= 16'd0;
			bit_q   <= 3'd0;
			cap_q   <= 15'd0;
			last_q  <= 15'd0;
		end else if (push) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			bit_q   <= bit_d;
			cap_q   <= cap_d;
			last_q  <= last_d;
		end
	end

	// Two-entry output buffer: the skid entry only fills while the output entry stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_q <= skid_v_q ? skid_q : res;
		end
		if (out_v_q && !pop && push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, out_q};

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds an item while the output entry is empty");

	a_bit_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q != 3'd0 |-> (phase_q == PH_CLK_HIGH || phase_q == PH_CLK_LOW))
		else $error("serial bit index set outside the clocking phases");

	a_report_updates_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && rep_valid |=> last_q == $past(cap_d) && phase_q == PH_DONE)
		else $error("reported capture not recorded or scan not finished");

	a_report_only_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		push && rep_valid |-> cap_d != last_q && phase_q == PH_CLK_LOW)
		else $error("report emitted without a finished, changed capture");

endmodule

// ===== verif/testbench.sv =====
module testbench
	import gssr_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// Tracks the scan state of the reader tick by tick.
	// It keeps the results that are still owed and checks each result item that arrives.
	class scan_report_tracker;
		logic [15:0] half_period;
		phase_t      phase;
		logic [15:0] wait_ticks;
		logic [2:0]  bit_pos;
		logic [14:0] capture;
		logic [14:0] last_sent;
		res_t        pending[$];
		int          ticks;
		int          results;
		int          reports;
		int          mismatches;

		function new();
			half_period = HALF_PERIOD_RESET;
			phase       = PH_IDLE;
			wait_ticks  = '0;
			bit_pos     = '0;
			capture     = '0;
			last_sent   = '0;
			ticks       = 0;
			results     = 0;
			reports     = 0;
			mismatches  = 0;
		endfunction

		// A half period of zero behaves as one, and the compare covers that.
		function bit wait_ends();
			return ({1'b0, wait_ticks} + 17'd1) >= {1'b0, half_period};
		endfunction

		function bit busy();
			return phase == PH_SETTLE || phase == PH_CLK_HIGH || phase == PH_CLK_LOW;
		endfunction

		function bit samples_now();
			return (phase == PH_SETTLE || phase == PH_CLK_LOW) && wait_ends();
		endfunction

		function void note_tick(bit start, logic [3:0] dirs, bit fire, bit data);
			res_t        r;
			bit          ends;
			logic [14:0] lo;
			ends = wait_ends();
			r = '0;
			ticks++;
			if (busy())
				wait_ticks = ends ? 16'd0 : wait_ticks + 16'd1;
			case (phase)
			PH_SETTLE: begin
				if (ends) begin
					capture = {9'd0, data, fire, dirs};
					bit_pos = '0;
					phase   = PH_CLK_HIGH;
				end
			end
			PH_CLK_HIGH: begin
				if (ends)
					phase = PH_CLK_LOW;
			end
			PH_CLK_LOW: begin
				if (ends) begin
					if (int'(bit_pos) + 8 < 15)
						capture[int'(bit_pos) + 8] = data;
					if (int'(bit_pos) + 1 >= int'(SCAN_BITS)) begin
						bit_pos = '0;
						phase   = PH_DONE;
						if (capture != last_sent) begin
							lo = ~capture;
							r.report_valid = 1'b1;
							r.report_x = lo[2] ? AXIS_LOW : (lo[3] ? AXIS_HIGH : AXIS_CENTRE);
							r.report_y = lo[0] ? AXIS_LOW : (lo[1] ? AXIS_HIGH : AXIS_CENTRE);
							r.report_buttons = {lo[14], 1'b0, lo[12], lo[13], lo[11],
								lo[4] | lo[9], lo[5] | lo[8], lo[10]};
							last_sent = capture;
						end
					end else begin
						bit_pos = bit_pos + 3'd1;
						phase   = PH_CLK_HIGH;
					end
				end
			end
			default: begin
				if (phase != PH_DONE)
					phase = PH_IDLE;
				if (start) begin
					phase      = PH_SETTLE;
					wait_ticks = '0;
					bit_pos    = '0;
				end
			end
			endcase
			r.scan_mode   = phase == PH_CLK_HIGH || phase == PH_CLK_LOW || phase == PH_DONE;
			r.clock_level = phase == PH_CLK_HIGH || phase == PH_DONE;
			r.busy_res    = busy();
			pending.push_back(r);
		endfunction

		function void check_result(logic [31:0] word);
			res_t got;
			res_t want;
			got = word[27:0];
			results++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result item %0d arrived with nothing owed: %h", results, word);
				return;
			end
			want = pending.pop_front();
			if (got !== want || word[31:28] !== 4'h0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: item %0d: expected mode %b clk %b busy %b valid %b",
						results, want.scan_mode, want.clock_level, want.busy_res,
						want.report_valid);
					$display("       x %h y %h buttons %h pad 0",
						want.report_x, want.report_y, want.report_buttons);
					$display("       got mode %b clk %b busy %b valid %b",
						got.scan_mode, got.clock_level, got.busy_res, got.report_valid);
					$display("       x %h y %h buttons %h pad %h",
						got.report_x, got.report_y, got.report_buttons, word[31:28]);
				end
			end else if (got.report_valid) begin
				reports++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	// bit 0 start_req, bits 4:1 dir_pins, bit 5 fire_pin, bit 6 data_pin, bit 7 zero
	logic [7:0]  s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// bit 0 scan_mode, bit 1 clock_level, bit 2 busy_res, bit 3 report_valid,
	// bits 11:4 report_x, bits 19:12 report_y, bits 27:20 report_buttons, 31:28 zero
	logic [31:0] m_tdata;

	// Chance, in percent, that the sender leaves a cycle empty or the receiver stalls.
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;

	scan_report_tracker tracker = new();

	gamepad_serial_scan_reporter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver decides afresh on every edge whether it will take the next item.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Values are read in the active region straight after the edge, so they are the
	// levels that the block saw at that edge, before any register has moved.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	// Offers one tick and returns at the edge that takes it. Valid is left high, so that
	// back-to-back ticks never see it lowered and raised again within one time step.
	task automatic send_tick(bit start, logic [3:0] dirs, bit fire, bit data);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, data, fire, dirs, start};
		do @(posedge clk); while (!s_tready);
		tracker.note_tick(start, dirs, fire, data);
	endtask

	// A tick whose pin levels should make no difference. The start request may be set
	// only where the block is busy and has to ignore it.
	task automatic send_noise(bit start_allowed);
		send_tick(start_allowed ? 1'($urandom_range(1)) : 1'b0, 4'($urandom_range(15)),
			1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// One tick of a running scan. The pins carry the wanted capture only on the ticks
	// where the block samples them; on all other ticks they carry random levels, so that
	// a block which samples at the wrong moment picks up the wrong value.
	task automatic scan_tick(logic [14:0] want);
		if (tracker.samples_now() && tracker.phase == PH_SETTLE)
			send_tick(1'($urandom_range(1)), want[3:0], want[4], want[5]);
		else if (tracker.samples_now())
			send_tick(1'($urandom_range(1)), 4'($urandom_range(15)),
				1'($urandom_range(1)), want[8 + tracker.bit_pos]);
		else
			send_noise(1'b1);
	endtask

	// One whole scan, from the start request to the last serial bit.
	task automatic run_scan(logic [14:0] want);
		send_tick(1'b1, 4'($urandom_range(15)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		while (tracker.busy())
			scan_tick(want);
	endtask

	// Stops offering ticks and lets every owed result drain before going on.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Only called with nothing in flight.
	task automatic write_half_period(logic [15:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tracker.half_period = value;
	endtask

	initial begin
		logic [14:0] target;
		logic [14:0] prev_target;
		int          stop_at;
		int          idle_plan[4];
		int          stall_plan[4];
		logic [15:0] period_plan[8];
		logic [14:0] directed[10];

		idle_plan   = '{0, 51, 0, 27};
		stall_plan  = '{0, 0, 51, 27};
		period_plan = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd4, 16'd2, 16'd1};
		// Released pad, left with right, the same again, right with down, up with down,
		// red alone, blue alone, two alternating serial patterns, and everything pressed.
		directed = '{15'h7F3F, 15'h7F33, 15'h7F33, 15'h7F35, 15'h7F3C,
			15'h7F2F, 15'h7F1F, 15'h2A3F, 15'h553F, 15'h0000};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first scan starts on the half period left by reset: its settle wait and its
		// first clock-high wait run in full, then the half period is shortened while the
		// scan is still running. An all-pressed capture equals the cleared last report,
		// so this scan must finish without a report.
		repeat (3) send_noise(1'b0);
		send_tick(1'b1, 4'($urandom_range(15)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		stop_at = tracker.ticks + 230;
		while (tracker.ticks < stop_at)
			scan_tick(15'h0000);
		drain_results();
		write_half_period(16'd1);
		while (tracker.busy())
			scan_tick(15'h0000);
		drain_results();

		// Directed captures on the shortest half period, then two on a half period of zero.
		foreach (directed[i])
			run_scan(directed[i]);
		drain_results();
		write_half_period(16'd0);
		run_scan(15'h7F3F);
		run_scan(15'h0F30);
		drain_results();

		// Random scans on short half periods, rotating through the idling patterns.
		// About a quarter of the scans repeat the previous capture, which must not be reported.
		prev_target = 15'h0F30;
		for (int p = 0; p < 8; p++) begin
			sender_idle_pct    = idle_plan[p % 4];
			receiver_stall_pct = stall_plan[p % 4];
			write_half_period(period_plan[p]);
			stop_at = tracker.ticks + 80;
			while (tracker.ticks < stop_at) begin
				repeat ($urandom_range(3)) send_noise(1'b0);
				if ($urandom_range(3) == 0)
					target = prev_target;
				else
					target = 15'($urandom_range(16'h7FFF)) & 15'h7F3F;
				run_scan(target);
				prev_target = target;
			end
			drain_results();
		end

		// The longest half period: only the start of the settle wait fits in the run.
		sender_idle_pct    = idle_plan[3];
		receiver_stall_pct = stall_plan[3];
		write_half_period(16'hFFFF);
		send_tick(1'b1, 4'($urandom_range(15)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		repeat (150) send_noise(1'b1);
		drain_results();
		repeat (10) @(posedge clk);

		$display("Ran %0d ticks and checked %0d result items, %0d of them reports,",
			tracker.ticks, tracker.results, tracker.reports);
		$display("over half periods 0 to 65535 with idle and stall patterns; %0d mismatches.",
			tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("ERROR: run timed out");
		$display("Some tests failed");
		$finish;
	end

endmodule
